FILE: sv/mrfc_pkg.sv
// Shared types and constants for the motor reply frame checker.
package mrfc_pkg;

  // Frame layout
  localparam int REPLY_LENGTH  = 13;
  localparam int LAST_POS      = REPLY_LENGTH - 1;
  localparam int HSUM_POS      = 4;
  localparam int PAYLOAD_START = 5;
  localparam int PAYLOAD_COUNT = 7;
  localparam int POS_W         = $clog2(REPLY_LENGTH + 1);
  localparam int PIDX_W        = $clog2(PAYLOAD_COUNT);

  localparam logic [7:0] HEADER_RESET = 8'd62;

  // Frame status codes, first failing check wins
  typedef enum logic [1:0] {
    STATUS_GOOD       = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_HEADER_SUM = 2'd2,
    STATUS_DATA_SUM   = 2'd3
  } status_t;

  // One result transaction
  typedef struct packed {
    status_t            frame_status;
    logic signed [7:0]  temperature;
    logic signed [15:0] torque_or_power;
    logic signed [15:0] speed;
    logic [15:0]        encoder_position;
  } result_t;

endpackage

FILE: sv/mrfc_if.sv
// Stream interfaces for received bytes and frame results.
interface mrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       first_byte;

  modport source (output valid, output rx_byte, output first_byte, input ready);
  modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface mrfc_out_if;
  logic                 valid;
  logic                 ready;
  mrfc_pkg::status_t    frame_status;
  logic signed [7:0]    temperature;
  logic signed [15:0]   torque_or_power;
  logic signed [15:0]   speed;
  logic [15:0]          encoder_position;

  modport source (output valid, output frame_status, output temperature,
                  output torque_or_power, output speed, output encoder_position,
                  input ready);
  modport sink   (input valid, input frame_status, input temperature,
                  input torque_or_power, input speed, input encoder_position,
                  output ready);
endinterface

FILE: sv/mrfc_frame_track.sv
// Byte position tracking, additive sum checks and held motor values.
module mrfc_frame_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             first_byte,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output logic             res_load,
  output mrfc_pkg::result_t res
);
  import mrfc_pkg::*;

  logic [7:0]        header_value;
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  byte_position_next;
  logic [7:0]        running_sum;
  logic [7:0]        running_sum_next;
  logic              header_matched;
  logic              header_matched_next;
  logic              header_sum_good;
  logic              header_sum_good_next;
  logic [7:0]        payload_bytes [PAYLOAD_COUNT];
  logic              payload_we;
  logic [PIDX_W-1:0] payload_idx;
  logic signed [7:0]  held_temperature;
  logic signed [15:0] held_torque;
  logic signed [15:0] held_speed;
  logic [15:0]        held_encoder;
  logic [POS_W-1:0]  pos;
  logic              in_frame;
  logic              is_last;
  status_t           status;

  // Restart the count on a start flag
  assign pos      = first_byte ? '0 : byte_position;
  assign in_frame = (pos < POS_W'(REPLY_LENGTH));
  assign is_last  = (pos == POS_W'(LAST_POS));
  assign payload_idx = PIDX_W'(pos - POS_W'(PAYLOAD_START));

  // Advance position and sums for one byte
  always_comb begin
    byte_position_next   = byte_position;
    running_sum_next     = running_sum;
    header_matched_next  = header_matched;
    header_sum_good_next = header_sum_good;
    payload_we           = 1'b0;
    if (in_frame) begin
      byte_position_next = pos + POS_W'(1);
      if (pos == '0) begin
        header_matched_next = (rx_byte == header_value);
        running_sum_next    = rx_byte;
      end else if (pos < POS_W'(HSUM_POS)) begin
        running_sum_next = running_sum + rx_byte;
      end else if (pos == POS_W'(HSUM_POS)) begin
        header_sum_good_next = (rx_byte == running_sum);
        running_sum_next     = '0;
      end else if (pos < POS_W'(LAST_POS)) begin
        payload_we       = 1'b1;
        running_sum_next = running_sum + rx_byte;
      end
    end
  end

  // Pick the status on the last byte
  always_comb begin
    if (!header_matched)             status = STATUS_BAD_HEADER;
    else if (!header_sum_good)       status = STATUS_HEADER_SUM;
    else if (rx_byte != running_sum) status = STATUS_DATA_SUM;
    else                             status = STATUS_GOOD;
  end

  // Build the result from updated or held values
  always_comb begin
    res.frame_status = status;
    if (status == STATUS_GOOD) begin
      res.temperature      = payload_bytes[0];
      res.torque_or_power  = {payload_bytes[2], payload_bytes[1]};
      res.speed            = {payload_bytes[4], payload_bytes[3]};
      res.encoder_position = {payload_bytes[6], payload_bytes[5]};
    end else begin
      res.temperature      = held_temperature;
      res.torque_or_power  = held_torque;
      res.speed            = held_speed;
      res.encoder_position = held_encoder;
    end
  end

  assign res_load = accept && is_last;

  // Control state and held values
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value     <= HEADER_RESET;
      byte_position    <= '0;
      running_sum      <= '0;
      header_matched   <= 1'b0;
      header_sum_good  <= 1'b0;
      held_temperature <= '0;
      held_torque      <= '0;
      held_speed       <= '0;
      held_encoder     <= '0;
    end else begin
      if (cfg_we) begin
        header_value <= cfg_wdata;
      end
      if (accept) begin
        byte_position   <= byte_position_next;
        running_sum     <= running_sum_next;
        header_matched  <= header_matched_next;
        header_sum_good <= header_sum_good_next;
      end
      if (res_load) begin
        held_temperature <= res.temperature;
        held_torque      <= res.torque_or_power;
        held_speed       <= res.speed;
        held_encoder     <= res.encoder_position;
      end
    end
  end

  // Store payload bytes
  always_ff @(posedge clk) begin
    if (accept && payload_we) begin
      payload_bytes[payload_idx] <= rx_byte;
    end
  end

endmodule

FILE: sv/mrfc_result_reg.sv
// Output register that holds one result transaction until it is taken.
module mrfc_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mrfc_pkg::result_t res,
  output logic              can_accept,
  mrfc_out_if.source        out
);
  import mrfc_pkg::*;

  logic    valid;
  result_t data;

  // Take a new byte whenever the register is free or draining
  assign can_accept = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign out.valid            = valid;
  assign out.frame_status     = data.frame_status;
  assign out.temperature      = data.temperature;
  assign out.torque_or_power  = data.torque_or_power;
  assign out.speed            = data.speed;
  assign out.encoder_position = data.encoder_position;

endmodule

FILE: sv/motor_reply_frame_checker.sv
// Top level of the motor reply frame checker.
// Checks a 13-byte motor reply taken one byte per transaction: a byte with
// first_byte set restarts at position zero. Byte 0 must match header_value,
// byte 4 the 8-bit sum of bytes 0..3, byte 12 the 8-bit sum of bytes 5..11.
// Byte 12 yields one result transaction with the status and the held motor
// values, which are reloaded from the little-endian payload only on a good
// frame. Bytes past position 12 are dropped until the next start flag. A byte
// may be accepted every cycle unless input stalls, which it does only while
// the single output register is full and not being taken; that register
// shows the result of byte 12 in the cycle after that byte is accepted.
// Write header_value only while the block is idle.
module motor_reply_frame_checker (
  input  logic       clk,
  input  logic       rst,
  mrfc_in_if.sink    in,
  mrfc_out_if.source out,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import mrfc_pkg::*;

  logic    accept;
  logic    can_accept;
  logic    res_load;
  result_t res;

  assign in.ready = can_accept;
  assign accept   = in.valid && can_accept;

  mrfc_frame_track u_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (in.rx_byte),
    .first_byte (in.first_byte),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_load   (res_load),
    .res        (res)
  );

  mrfc_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .res        (res),
    .can_accept (can_accept),
    .out        (out)
  );

endmodule
